>>> design/gbcb_pkg.sv
// Shared types, constants and helpers for the grid best-corner bucketing block.
// Used by every module of the block except gbcb_ram; depends on nothing.
`timescale 1ns / 1ps

package gbcb_pkg;

  localparam int unsigned MAX_CELLS_DEF = 1024;
  localparam int unsigned MAX_LEVELS    = 8;
  localparam int unsigned COORD_BITS    = 12;
  localparam int unsigned LVL_W         = 3;
  localparam int unsigned SCORE_W       = 32;
  localparam int unsigned GEOM_W        = 11;
  localparam int unsigned CS_W          = 8;
  localparam int unsigned IDX_OUT_W     = 10;
  // Full-resolution coordinate before the overflow check: 12 bits shifted by up to 7
  localparam int unsigned FULL_W        = COORD_BITS + (1 << LVL_W) - 1;
  localparam int unsigned POS_W         = 2 * COORD_BITS + LVL_W;
  localparam int unsigned PROD_W        = 2 * GEOM_W;
  localparam int unsigned CELL_FIELD_W  = 16;
  // Memory word: occupied, valid, best score, best position
  localparam int unsigned WORD_W        = 2 + SCORE_W + POS_W;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [SCORE_W-1:0] THR_RESET  = '0;
  localparam logic [CS_W-1:0]    CS_RESET   = 8'd30;
  localparam logic [GEOM_W-1:0]  COLS_RESET = 11'd22;
  localparam logic [GEOM_W-1:0]  ROWS_RESET = 11'd16;

  typedef enum logic [1:0] {
    ACT_MARK  = 2'd0,
    ACT_CAND  = 2'd1,
    ACT_DRAIN = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_CELL_SIZE = 2'd1,
    REG_GRID_COLS = 2'd2,
    REG_GRID_ROWS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    Q_MARK,
    Q_CAND,
    Q_DRAIN
  } q_kind_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_CHK,
    F_IDX,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [COORD_BITS-1:0] x_level;
    logic [COORD_BITS-1:0] y_level;
    logic [LVL_W-1:0]      pyr_level;
    logic [SCORE_W-1:0]    score;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  cell_index;
    logic                  found;
    logic [COORD_BITS-1:0] corner_x;
    logic [COORD_BITS-1:0] corner_y;
    logic [LVL_W-1:0]      corner_level;
    logic                  last;
  } out_item_t;

  // Effective geometry, zero registers already replaced by one
  typedef struct packed {
    logic [CS_W-1:0]   side;
    logic [GEOM_W-1:0] cols;
    logic [GEOM_W-1:0] rows;
  } geom_t;

  // Located item passed from front to back
  typedef struct packed {
    q_kind_e                 kind;
    logic [CELL_FIELD_W-1:0] slot;
    logic [SCORE_W-1:0]      score;
    logic [POS_W-1:0]        pos;
  } q_item_t;

  // Cells in use: product capped at the store depth
  function automatic logic [PROD_W-1:0] cap_cells(logic [PROD_W-1:0] prod,
                                                  logic [PROD_W-1:0] limit);
    cap_cells = (prod > limit) ? limit : prod;
  endfunction

endpackage

>>> design/gbcb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gbcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/gbcb_front.sv
// Front end: accepts items, scales coordinates, finds the cell with a
// bit-serial divider and pushes located items. Depends on gbcb_pkg.
`timescale 1ns / 1ps

module gbcb_front #(
  parameter int unsigned MaxCells = gbcb_pkg::MAX_CELLS_DEF,
  parameter int unsigned TotW     = $clog2(MaxCells + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      go_i,
  input  gbcb_pkg::in_item_t        item_i,
  input  gbcb_pkg::geom_t           geom_i,
  input  logic [TotW-1:0]           total_i,
  output logic                      busy_o,
  output logic                      push_o,
  output gbcb_pkg::q_item_t         push_item_o,
  input  logic                      full_i
);
  import gbcb_pkg::*;

  localparam int unsigned CntW = $clog2(FULL_W);

  front_state_e             st_q, st_d;
  logic [FULL_W-1:0]        xd_q, xd_d, yd_q, yd_d;
  logic [CS_W:0]            xr_q, xr_d, yr_q, yr_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  q_kind_e                  kind_q, kind_d;
  logic [SCORE_W-1:0]       score_q, score_d;
  logic [POS_W-1:0]         pos_q, pos_d;
  logic                     bad_q, bad_d;
  logic [GEOM_W-1:0]        r_q, r_d, c_q, c_d;
  logic                     ingrid_q, ingrid_d;
  logic [CELL_FIELD_W-1:0]  cell_q, cell_d;

  logic [FULL_W-1:0]        fx, fy;
  logic [CS_W:0]            xr_sh, yr_sh;
  logic                     xq_bit, yq_bit;
  logic [PROD_W-1:0]        k_w;
  logic                     lvl_ok;

  // Scale to full resolution
  assign fx = FULL_W'(item_i.x_level) << item_i.pyr_level;
  assign fy = FULL_W'(item_i.y_level) << item_i.pyr_level;
  assign lvl_ok = ({1'b0, item_i.pyr_level} < (LVL_W + 1)'(MAX_LEVELS));

  // One restoring divide step per cycle on each coordinate
  assign xr_sh  = {xr_q[CS_W-1:0], xd_q[FULL_W-1]};
  assign yr_sh  = {yr_q[CS_W-1:0], yd_q[FULL_W-1]};
  assign xq_bit = (xr_sh >= {1'b0, geom_i.side});
  assign yq_bit = (yr_sh >= {1'b0, geom_i.side});

  assign k_w = PROD_W'(r_q) * PROD_W'(geom_i.cols) + PROD_W'(c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xd_q     <= xd_d;
    yd_q     <= yd_d;
    xr_q     <= xr_d;
    yr_q     <= yr_d;
    cnt_q    <= cnt_d;
    kind_q   <= kind_d;
    score_q  <= score_d;
    pos_q    <= pos_d;
    bad_q    <= bad_d;
    r_q      <= r_d;
    c_q      <= c_d;
    ingrid_q <= ingrid_d;
    cell_q   <= cell_d;
  end

  always_comb begin
    st_d     = st_q;
    xd_d     = xd_q;
    yd_d     = yd_q;
    xr_d     = xr_q;
    yr_d     = yr_q;
    cnt_d    = cnt_q;
    kind_d   = kind_q;
    score_d  = score_q;
    pos_d    = pos_q;
    bad_d    = bad_q;
    r_d      = r_q;
    c_d      = c_q;
    ingrid_d = ingrid_q;
    cell_d   = cell_q;
    push_o   = 1'b0;
    case (st_q)
      F_IDLE: begin
        // Take the item and classify it
        if (go_i) begin
          xd_d    = fx;
          yd_d    = fy;
          xr_d    = '0;
          yr_d    = '0;
          cnt_d   = CntW'(FULL_W - 1);
          score_d = item_i.score;
          pos_d   = {item_i.pyr_level, fy[COORD_BITS-1:0], fx[COORD_BITS-1:0]};
          cell_d  = '0;
          case (action_e'(item_i.action))
            ACT_MARK: begin
              kind_d = Q_MARK;
              bad_d  = !lvl_ok;
              st_d   = F_DIV;
            end
            ACT_CAND: begin
              kind_d = Q_CAND;
              bad_d  = !lvl_ok || (fx[FULL_W-1:COORD_BITS] != '0)
                       || (fy[FULL_W-1:COORD_BITS] != '0);
              st_d   = F_DIV;
            end
            ACT_DRAIN: begin
              kind_d = Q_DRAIN;
              bad_d  = 1'b0;
              st_d   = F_PUSH;
            end
            default: begin
              st_d = F_IDLE;
            end
          endcase
        end
      end
      F_DIV: begin
        // Shift the quotient into the dividend registers
        xr_d = xq_bit ? (xr_sh - {1'b0, geom_i.side}) : xr_sh;
        yr_d = yq_bit ? (yr_sh - {1'b0, geom_i.side}) : yr_sh;
        xd_d = {xd_q[FULL_W-2:0], xq_bit};
        yd_d = {yd_q[FULL_W-2:0], yq_bit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          st_d = F_CHK;
        end
      end
      F_CHK: begin
        // Check column and row against the grid
        ingrid_d = (xd_q < FULL_W'(geom_i.cols)) && (yd_q < FULL_W'(geom_i.rows));
        c_d      = xd_q[GEOM_W-1:0];
        r_d      = yd_q[GEOM_W-1:0];
        st_d     = F_IDX;
      end
      F_IDX: begin
        // Form the cell index and drop flagged items and items outside the cells in use
        cell_d = k_w[CELL_FIELD_W-1:0];
        if (ingrid_q && !bad_q && (k_w < PROD_W'(total_i))) begin
          st_d = F_PUSH;
        end else begin
          st_d = F_IDLE;
        end
      end
      F_PUSH: begin
        // Hold until the queue has room
        if (!full_i) begin
          push_o = 1'b1;
          st_d   = F_IDLE;
        end
      end
      default: begin
        st_d = F_IDLE;
      end
    endcase
  end

  assign busy_o      = (st_q != F_IDLE);
  assign push_item_o = '{kind: kind_q, slot: cell_q, score: score_q, pos: pos_q};

endmodule

>>> design/gbcb_back.sv
// Back end: clears the cell store after reset, then runs the read-modify-write
// of each located item and the drain scan. Depends on gbcb_pkg and gbcb_ram.
`timescale 1ns / 1ps

module gbcb_back #(
  parameter int unsigned MaxCells = gbcb_pkg::MAX_CELLS_DEF,
  parameter int unsigned TotW     = $clog2(MaxCells + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  gbcb_pkg::q_item_t           item_i,
  output logic                        pop_o,
  input  logic [gbcb_pkg::SCORE_W-1:0] thr_i,
  input  logic [TotW-1:0]             total_i,
  output logic                        clearing_o,
  output logic                        res_valid_o,
  output gbcb_pkg::out_item_t         res_o
);
  import gbcb_pkg::*;

  localparam int unsigned CellW = (MaxCells > 1) ? $clog2(MaxCells) : 1;

  back_state_e          st_q, st_d;
  logic [CellW-1:0]     clr_q, clr_d;
  logic [CellW-1:0]     sp_q, sp_d;
  q_kind_e              kind_q, kind_d;
  logic [CellW-1:0]     k_q, k_d;
  logic [SCORE_W-1:0]   score_q, score_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 res_valid_q, res_valid_d;
  out_item_t            res_q, res_d;

  logic                 we;
  logic [CellW-1:0]     waddr, raddr;
  logic [WORD_W-1:0]    wdata, rdata;
  logic                 r_occ, r_vld, found;
  logic [SCORE_W-1:0]   r_score;
  logic [POS_W-1:0]     r_pos;
  logic [CellW-1:0]     k_drain;
  logic [TotW-1:0]      k_next;
  logic [CellW+IDX_OUT_W-1:0] k_ext;

  gbcb_ram #(
    .Width(WORD_W),
    .Depth(MaxCells)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign {r_occ, r_vld, r_score, r_pos} = rdata;
  assign k_drain = (TotW'(sp_q) >= total_i) ? '0 : sp_q;
  assign k_next  = TotW'(k_q) + 1'b1;
  assign found   = r_vld && (r_score > thr_i);
  assign k_ext   = {{IDX_OUT_W{1'b0}}, k_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_CLEAR;
      clr_q       <= '0;
      sp_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      sp_q        <= sp_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    k_q     <= k_d;
    score_q <= score_d;
    pos_q   <= pos_d;
    res_q   <= res_d;
  end

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    sp_d        = sp_q;
    kind_d      = kind_q;
    k_d         = k_q;
    score_d     = score_q;
    pos_d       = pos_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = k_q;
    wdata       = rdata;
    raddr       = item_i.slot[CellW-1:0];
    case (st_q)
      B_CLEAR: begin
        // Sweep the store to empty cells
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == CellW'(MaxCells - 1)) begin
          st_d = B_IDLE;
        end
      end
      B_IDLE: begin
        // Pop the next item and read its cell
        if (avail_i) begin
          pop_o   = 1'b1;
          kind_d  = item_i.kind;
          score_d = item_i.score;
          pos_d   = item_i.pos;
          if (item_i.kind == Q_DRAIN) begin
            raddr = k_drain;
            k_d   = k_drain;
          end else begin
            k_d = item_i.slot[CellW-1:0];
          end
          st_d = B_EXEC;
        end
      end
      B_EXEC: begin
        // Update the cell and report drained cells
        st_d = B_IDLE;
        case (kind_q)
          Q_MARK: begin
            we    = 1'b1;
            wdata = {1'b1, r_vld, r_score, r_pos};
          end
          Q_CAND: begin
            we    = !r_occ && (score_q > (r_vld ? r_score : thr_i));
            wdata = {1'b0, 1'b1, score_q, pos_q};
          end
          Q_DRAIN: begin
            we          = 1'b1;
            wdata       = {1'b0, 1'b0, r_score, r_pos};
            res_valid_d = 1'b1;
            res_d.cell_index   = k_ext[IDX_OUT_W-1:0];
            res_d.found        = found;
            res_d.corner_x     = found ? r_pos[COORD_BITS-1:0] : '0;
            res_d.corner_y     = found ? r_pos[2*COORD_BITS-1:COORD_BITS] : '0;
            res_d.corner_level = found ? r_pos[POS_W-1:2*COORD_BITS] : '0;
            res_d.last         = (k_next == total_i);
            sp_d = (k_next >= total_i) ? '0 : k_next[CellW-1:0];
          end
          default: begin
            we = 1'b0;
          end
        endcase
      end
      default: begin
        st_d = B_IDLE;
      end
    endcase
  end

  assign clearing_o  = (st_q == B_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/grid_best_corner_bucketing.sv
// Top level of the grid best-corner bucketing block: configuration registers,
// front end, item queue and back end. Depends on gbcb_pkg, gbcb_front, gbcb_back.
`timescale 1ns / 1ps

// Keeps the best-scoring corner of each grid cell. After reset the block runs
// a clearing pass over all MaxCells cells of the store (1024 by default)
// with busy high; configuration writes are taken during that time. A mark or
// candidate item keeps the front end busy while the one-bit-per-cycle cell
// divider runs its 19 steps, then through the check and index states and, for
// kept items, the push state, which waits while the queue is full. A drain item
// goes straight to the push state; its result appears as a one-cycle strobe on
// result_valid_o after the back end's read and write of the cell store. The
// receiver cannot stall: every strobe must be taken in the cycle it is shown.
// Mark and candidate items give no result; each drain item gives exactly one.
module grid_best_corner_bucketing #(
  parameter int unsigned MaxCells = gbcb_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  gbcb_pkg::in_item_t          in_item_i,
  output logic                        result_valid_o,
  output gbcb_pkg::out_item_t         result_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [gbcb_pkg::SCORE_W-1:0] cfg_wdata_i
);
  import gbcb_pkg::*;

  localparam int unsigned TotW = $clog2(MaxCells + 1);
  localparam logic [PROD_W-1:0] CellLimit = PROD_W'(MaxCells);

  logic [SCORE_W-1:0] thr_q;
  logic [CS_W-1:0]    cs_q;
  logic [GEOM_W-1:0]  cols_q, rows_q;
  geom_t              geom;
  logic [TotW-1:0]    total_q;
  logic [PROD_W-1:0]  prod;

  logic               go, front_busy, clearing;
  logic               push, pop, full, empty;
  q_item_t            push_item;
  q_item_t            fifo_q [QUEUE_DEPTH];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THR_RESET;
      cs_q   <= CS_RESET;
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_THRESHOLD: thr_q  <= cfg_wdata_i;
        REG_CELL_SIZE: cs_q   <= cfg_wdata_i[CS_W-1:0];
        REG_GRID_COLS: cols_q <= cfg_wdata_i[GEOM_W-1:0];
        REG_GRID_ROWS: rows_q <= cfg_wdata_i[GEOM_W-1:0];
        default: begin
          thr_q <= thr_q;
        end
      endcase
    end
  end

  // Treat zero geometry as one
  assign geom.side = (cs_q == '0) ? CS_W'(1) : cs_q;
  assign geom.cols = (cols_q == '0) ? GEOM_W'(1) : cols_q;
  assign geom.rows = (rows_q == '0) ? GEOM_W'(1) : rows_q;
  assign prod      = PROD_W'(geom.cols) * PROD_W'(geom.rows);

  // Register the count of cells in use
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotW'(cap_cells(PROD_W'(COLS_RESET) * PROD_W'(ROWS_RESET), CellLimit));
    end else begin
      total_q <= TotW'(cap_cells(prod, CellLimit));
    end
  end

  assign busy = front_busy || clearing;
  assign go   = start && !busy;

  gbcb_front #(
    .MaxCells(MaxCells),
    .TotW    (TotW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (go),
    .item_i     (in_item_i),
    .geom_i     (geom),
    .total_i    (total_q),
    .busy_o     (front_busy),
    .push_o     (push),
    .push_item_o(push_item),
    .full_i     (full)
  );

  // Item queue between front and back
  assign full  = (cnt_q == 2'(QUEUE_DEPTH));
  assign empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= push_item;
    end
  end

  gbcb_back #(
    .MaxCells(MaxCells),
    .TotW    (TotW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (!empty),
    .item_i     (fifo_q[rp_q]),
    .pop_o      (pop),
    .thr_i      (thr_q),
    .total_i    (total_q),
    .clearing_o (clearing),
    .res_valid_o(result_valid_o),
    .res_o      (result_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("queue pop while empty");
  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("results on adjacent cycles");
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !pop && !result_valid_o) else $error("item handled during clearing");
`endif

endmodule
